>>> hdl/esd_pkg.sv
// shared types and constants for the escape sequence decoder
// no dependencies; imported by esd_decoder, esd_result_fifo and the top level
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

    // saturation point of the per-string index and byte counters
    localparam int unsigned MAX_LEN = 65535;
    localparam int unsigned CAP_INT = (MAX_LEN < 65535) ? MAX_LEN : 65535;
    localparam logic [15:0] CAP     = 16'(CAP_INT);

    // result queue sizing
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    // result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } esd_kind_t;

    // parser modes
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX1   = 3'd2,
        MODE_HEX2   = 3'd3,
        MODE_OCT    = 3'd4
    } esd_mode_t;

    // one result item
    typedef struct packed {
        esd_kind_t   kind;
        logic [7:0]  out_byte;
        logic [15:0] amount;
        logic        string_end;
    } esd_result_t;

    // results produced by one input item, in delivery order
    typedef struct packed {
        logic [1:0]  count;
        esd_result_t r0;
        esd_result_t r1;
    } esd_push_t;

endpackage

`default_nettype wire

>>> hdl/escape_sequence_decoder_unit.sv
// an accepted item is registered in the input stage, then written into the result queue, which shows its first result
// throughput: one item per cycle while the result queue has room; an item with two results gives them in turn
// the rate is set by the single-pass decoder, the one-item-per-cycle result queue port and its room flag
// reset: synchronous active-low aresetn clears parser state, input stage and queue
// top level: input stage, decoder and result queue of the escape sequence decoder
// depends on esd_pkg, esd_decoder and esd_result_fifo
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] amount
    output logic [1:0]       m_tuser,   // [1:0] result_kind
    output logic             m_tlast    // string_end
);
    import esd_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        room;
    esd_push_t   push;
    esd_result_t head;

    assign s_tready = room;

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
        end
    end

    esd_decoder u_dec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .in_char  (in_char_reg),
        .push     (push)
    );

    esd_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (head)
    );

    // result item onto the master stream
    assign m_tdata = {head.amount, head.out_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.string_end;

    a_last_not_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser != KIND_BYTE))
        else $error("string end on a byte result");

endmodule

`default_nettype wire

>>> hdl/esd_decoder.sv
// per-string parser state and single-pass decode of one character
// depends on esd_pkg; produces up to two results per item for the result queue
`timescale 1ns / 1ps
`default_nettype none

module esd_decoder (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic [7:0]        in_char,
    output esd_pkg::esd_push_t     push
);
    import esd_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;

    // hex digit value, bit 4 flags a valid digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v < CAP) ? 16'(v + 16'd1) : v;
    endfunction

    function automatic esd_result_t mk_res(input esd_kind_t k, input logic [7:0] b,
                                           input logic [15:0] a, input logic e);
        esd_result_t r;
        r.kind       = k;
        r.out_byte   = b;
        r.amount     = a;
        r.string_end = e;
        return r;
    endfunction

    esd_mode_t   mode_reg,  mode_next;
    logic [7:0]  oval_reg,  oval_next;
    logic [1:0]  odig_reg,  odig_next;
    logic [3:0]  hexhi_reg, hexhi_next;
    logic [15:0] idx_reg,   idx_next;
    logic [15:0] cnt_reg,   cnt_next;
    logic        disc_reg,  disc_next;

    esd_result_t flush_res, main_res;
    logic        flush_vld, main_vld;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NORMAL;
            oval_reg  <= 8'd0;
            odig_reg  <= 2'd0;
            hexhi_reg <= 4'd0;
            idx_reg   <= 16'd0;
            cnt_reg   <= 16'd0;
            disc_reg  <= 1'b0;
        end else if (in_valid) begin
            mode_reg  <= mode_next;
            oval_reg  <= oval_next;
            odig_reg  <= odig_next;
            hexhi_reg <= hexhi_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            disc_reg  <= disc_next;
        end
    end

    // decode one character against the current state
    always_comb begin
        logic       is_oct;
        logic       done;
        logic       clr;
        logic [4:0] hd;
        logic [15:0] first;
        esd_mode_t  m;

        is_oct = (in_char >= CH_0) && (in_char <= CH_7);
        done   = 1'b0;
        clr    = 1'b0;
        hd     = hex_digit(in_char);
        first  = (idx_reg >= CAP || idx_reg == 16'd0) ? idx_reg : 16'(idx_reg - 16'd1);
        m      = mode_reg;

        mode_next  = mode_reg;
        oval_next  = oval_reg;
        odig_next  = odig_reg;
        hexhi_next = hexhi_reg;
        idx_next   = sat_inc(idx_reg);
        cnt_next   = cnt_reg;
        disc_next  = disc_reg;
        flush_vld  = 1'b0;
        main_vld   = 1'b0;
        flush_res  = mk_res(KIND_BYTE, 8'd0, 16'd0, 1'b0);
        main_res   = mk_res(KIND_BYTE, 8'd0, 16'd0, 1'b0);

        if (disc_reg) begin
            // dropping the rest of a bad string
            done = 1'b1;
            clr  = (in_char == CH_NUL);
        end else if (mode_reg == MODE_OCT) begin
            if (is_oct) begin
                done = 1'b1;
                oval_next = {oval_reg[4:0], in_char[2:0]};
                odig_next = 2'(odig_reg + 2'd1);
                if (odig_next == 2'd3) begin
                    main_vld  = 1'b1;
                    main_res  = mk_res(KIND_BYTE, oval_next, 16'd0, 1'b0);
                    cnt_next  = sat_inc(cnt_reg);
                    mode_next = MODE_NORMAL;
                    oval_next = 8'd0;
                    odig_next = 2'd0;
                end
            end else begin
                // non-digit closes the octal escape, then is parsed as normal text
                flush_vld = 1'b1;
                flush_res = mk_res(KIND_BYTE, oval_reg, 16'd0, 1'b0);
                cnt_next  = sat_inc(cnt_reg);
                oval_next = 8'd0;
                odig_next = 2'd0;
                m         = MODE_NORMAL;
            end
        end

        if (!done) begin
            mode_next = MODE_NORMAL;
            case (m)
                MODE_ESC: begin
                    main_vld = 1'b1;
                    case (in_char)
                        CH_BSL:   main_res.out_byte = 8'h5C;
                        CH_QUOTE: main_res.out_byte = 8'h27;
                        CH_DQUOT: main_res.out_byte = 8'h22;
                        CH_B:     main_res.out_byte = 8'h08;
                        CH_A:     main_res.out_byte = 8'h07;
                        CH_V:     main_res.out_byte = 8'h0B;
                        CH_T:     main_res.out_byte = 8'h09;
                        CH_N:     main_res.out_byte = 8'h0A;
                        CH_R:     main_res.out_byte = 8'h0D;
                        CH_X: begin
                            main_vld  = 1'b0;
                            mode_next = MODE_HEX1;
                        end
                        default: begin
                            if (is_oct) begin
                                main_vld  = 1'b0;
                                mode_next = MODE_OCT;
                                oval_next = {5'd0, in_char[2:0]};
                                odig_next = 2'd1;
                            end else begin
                                main_res = mk_res(KIND_ERR, 8'd0, idx_reg, 1'b1);
                                clr       = (in_char == CH_NUL);
                                disc_next = (in_char != CH_NUL);
                            end
                        end
                    endcase
                    if (main_vld && main_res.kind == KIND_BYTE) begin
                        cnt_next = sat_inc(cnt_next);
                    end
                end
                MODE_HEX1: begin
                    if (!hd[4]) begin
                        main_vld  = 1'b1;
                        main_res  = mk_res(KIND_ERR, 8'd0, idx_reg, 1'b1);
                        clr       = (in_char == CH_NUL);
                        disc_next = (in_char != CH_NUL);
                    end else begin
                        hexhi_next = hd[3:0];
                        mode_next  = MODE_HEX2;
                    end
                end
                MODE_HEX2: begin
                    main_vld = 1'b1;
                    if (!hd[4]) begin
                        main_res  = mk_res(KIND_ERR, 8'd0, first, 1'b1);
                        clr       = (in_char == CH_NUL);
                        disc_next = (in_char != CH_NUL);
                    end else begin
                        main_res   = mk_res(KIND_BYTE, {hexhi_reg, hd[3:0]}, 16'd0, 1'b0);
                        cnt_next   = sat_inc(cnt_next);
                        hexhi_next = 4'd0;
                    end
                end
                default: begin
                    if (in_char == CH_NUL) begin
                        main_vld = 1'b1;
                        main_res = mk_res(KIND_DONE, 8'd0, cnt_next, 1'b1);
                        clr      = 1'b1;
                    end else if (in_char == CH_BSL) begin
                        mode_next = MODE_ESC;
                    end else begin
                        main_vld = 1'b1;
                        main_res = mk_res(KIND_BYTE, in_char, 16'd0, 1'b0);
                        cnt_next = sat_inc(cnt_next);
                    end
                end
            endcase
        end

        // terminator resets all per-string state
        if (clr) begin
            mode_next  = MODE_NORMAL;
            oval_next  = 8'd0;
            odig_next  = 2'd0;
            hexhi_next = 4'd0;
            idx_next   = 16'd0;
            cnt_next   = 16'd0;
            disc_next  = 1'b0;
        end
    end

    // pack results in delivery order
    always_comb begin
        push.count = in_valid ? (2'(flush_vld) + 2'(main_vld)) : 2'd0;
        push.r0    = flush_vld ? flush_res : main_res;
        push.r1    = main_res;
    end

    // two results only when an octal escape is flushed first
    a_two_needs_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd2 |-> (mode_reg == MODE_OCT && push.r0.kind == KIND_BYTE))
        else $error("two results without an octal flush");

    // a discarding string gives nothing and leaves the mode untouched
    a_discard_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && disc_reg) |-> (push.count == 2'd0 && mode_next == mode_reg))
        else $error("result produced while discarding");

    // an error always ends or suspends the string
    a_err_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && !disc_reg && push.count != 2'd0 && push.r1.kind == KIND_ERR)
        |=> (disc_reg || idx_reg == 16'd0))
        else $error("error without discard or clear");

endmodule

`default_nettype wire

>>> hdl/esd_result_fifo.sv
// small result queue taking up to two items per cycle and giving one
// depends on esd_pkg; feeds the master stream of the top level
`timescale 1ns / 1ps
`default_nettype none

module esd_result_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  esd_pkg::esd_push_t       push,
    output logic                     room,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output esd_pkg::esd_result_t     out_item
);
    import esd_pkg::*;

    esd_result_t           mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      cnt_reg,    cnt_next;
    logic                  pop;
    logic [PTR_W-1:0]      wr_ptr_p1;

    assign pop       = out_valid && out_ready;
    assign wr_ptr_p1 = PTR_W'(wr_ptr_reg + PTR_W'(1));

    // pointer and fill level
    always_comb begin
        wr_ptr_next = PTR_W'(wr_ptr_reg + PTR_W'(push.count));
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        cnt_next    = CNT_W'(cnt_reg + CNT_W'(push.count) - CNT_W'(pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_p1] <= push.r1;
        end
    end

    // room for a pending item and a new one, two entries each
    assign room      = (cnt_reg <= CNT_W'(FIFO_DEPTH - 4));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

endmodule

`default_nettype wire
